[rtl/core/mtsl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtsl_pkg
// Shared types and constants for the two-list merge block.
// ----------------------------------------------------------------------------
package mtsl_pkg;

   localparam int DEPTH   = 16;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int VALUE_W = 32;
   localparam int ACT_W   = 2;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [CNT_W-1:0]          count_type;
   typedef logic [ADDR_W-1:0]         addr_type;
   typedef logic [ACT_W-1:0]          action_type;

   localparam action_type ACT_PUSH_FIRST  = 2'd0;
   localparam action_type ACT_PUSH_SECOND = 2'd1;
   localparam action_type ACT_MERGE       = 2'd2;

   localparam count_type DEPTH_CNT = CNT_W'(DEPTH);

endpackage

[rtl/core/mtsl_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtsl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mtsl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/merge_two_sorted_lists_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merge_two_sorted_lists_top
// Two lists of signed values in RAM, merged into one ascending stream.
// ----------------------------------------------------------------------------
//  Channel | Dir | Contents
//  req_*   | in  | tuser[1:0] action, tdata[31:0] value
//  rsp_*   | out | tdata[31:0] merged value, tlast last of merge,
//          |     | tuser[0] from second, [1] empty, [2] overflowed
//
//  A push is one RAM write at the list's fill count.
//  A merge of N stored values emits N results, one per cycle while the
//  output is free; each compares the two registered RAM heads and
//  prefetches the next entry of the list that advanced. Empty merge: one result.
//  Reset is synchronous; it clears counts, flag, pointers and the output.
//  A stalled output holds the merge in place; requests wait during a merge.
// ----------------------------------------------------------------------------
module merge_two_sorted_lists_top
   import mtsl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [1:0] action
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] merged_value
   output logic        rsp_tlast,   // is_last
   output logic [2:0]  rsp_tuser    // [0] from_second, [1] is_empty, [2] overflowed
);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_MERGE = 1'b1;

   logic      state_ff, state_in;
   count_type cnt_a_ff, cnt_a_in;
   count_type cnt_b_ff, cnt_b_in;
   count_type i_ff, i_in;
   count_type j_ff, j_in;
   logic      ovf_ff, ovf_in;

   // output register
   logic      rsp_valid_ff, rsp_valid_in;
   value_type rsp_data_ff, rsp_data_in;
   logic      rsp_sec_ff, rsp_sec_in;
   logic      rsp_last_ff, rsp_last_in;
   logic      rsp_empty_ff, rsp_empty_in;
   logic      rsp_ovf_ff, rsp_ovf_in;
   logic      rsp_load;

   // RAM ports
   logic      wr_a, wr_b;
   addr_type  rd_addr_a, rd_addr_b;
   value_type rd_a, rd_b;

   logic       out_free, req_fire, step;
   logic       avail_a, avail_b, take_a;
   action_type action;
   value_type  value;

   assign action   = req_tuser;
   assign value    = req_tdata;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_fire = req_tvalid && req_tready;

   // pushes; a full list drops the value
   assign wr_a = req_fire && (action == ACT_PUSH_FIRST)  && (cnt_a_ff < DEPTH_CNT);
   assign wr_b = req_fire && (action == ACT_PUSH_SECOND) && (cnt_b_ff < DEPTH_CNT);

   // merge selection on the registered heads; first list wins ties
   assign avail_a = i_ff < cnt_a_ff;
   assign avail_b = j_ff < cnt_b_ff;
   assign take_a  = avail_a && (!avail_b || (rd_a <= rd_b));
   assign step    = (state_ff == ST_MERGE) && out_free;

   assign i_in = i_ff + CNT_W'(step && take_a);
   assign j_in = j_ff + CNT_W'(step && !take_a);

   // prefetch: address the entry after the one taken so the head is ready
   assign rd_addr_a = i_in[ADDR_W-1:0];
   assign rd_addr_b = j_in[ADDR_W-1:0];

   always_comb begin
      state_in     = state_ff;
      cnt_a_in     = cnt_a_ff;
      cnt_b_in     = cnt_b_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_load     = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rsp_sec_in   = rsp_sec_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               priority if (action == ACT_PUSH_FIRST) begin
                  if (wr_a) begin
                     cnt_a_in = cnt_a_ff + count_type'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else if (action == ACT_PUSH_SECOND) begin
                  if (wr_b) begin
                     cnt_b_in = cnt_b_ff + count_type'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else if (action == ACT_MERGE) begin
                  if ((cnt_a_ff == '0) && (cnt_b_ff == '0)) begin
                     rsp_load     = 1'b1;
                     rsp_data_in  = '0;
                     rsp_sec_in   = 1'b0;
                     rsp_last_in  = 1'b1;
                     rsp_empty_in = 1'b1;
                     rsp_ovf_in   = ovf_ff;
                     ovf_in       = 1'b0;
                  end else begin
                     state_in = ST_MERGE;
                  end
               end else begin
                  // unused action: no effect
               end
            end
         end
         ST_MERGE: begin
            if (step) begin
               rsp_load     = 1'b1;
               rsp_data_in  = take_a ? rd_a : rd_b;
               rsp_sec_in   = !take_a;
               rsp_last_in  = (i_in == cnt_a_ff) && (j_in == cnt_b_ff);
               rsp_empty_in = 1'b0;
               rsp_ovf_in   = ovf_ff;
               if (rsp_last_in) begin
                  state_in = ST_IDLE;
                  cnt_a_in = '0;
                  cnt_b_in = '0;
                  ovf_in   = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         // pointers return to zero when the merge ends
         i_ff         <= (state_in == ST_IDLE) ? '0 : i_in;
         j_ff         <= (state_in == ST_IDLE) ? '0 : j_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff  <= rsp_data_in;
         rsp_sec_ff   <= rsp_sec_in;
         rsp_last_ff  <= rsp_last_in;
         rsp_empty_ff <= rsp_empty_in;
         rsp_ovf_ff   <= rsp_ovf_in;
      end
   end

   mtsl_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (cnt_a_ff[ADDR_W-1:0]),
      .wr_data (value),
      .rd_addr (rd_addr_a),
      .rd_data (rd_a)
   );

   mtsl_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (cnt_b_ff[ADDR_W-1:0]),
      .wr_data (value),
      .rd_addr (rd_addr_b),
      .rd_data (rd_b)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_ovf_ff, rsp_empty_ff, rsp_sec_ff};

endmodule

[rtl/core/mtsl_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtsl_checker
// Port-level checks for the two-list merge block.
// ----------------------------------------------------------------------------
module mtsl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic [2:0]  rsp_tuser
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // an empty merge is a single, final, zero result
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast && (rsp_tdata == 32'd0) && !rsp_tuser[0])
      else $error("empty result malformed");

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // requests are refused while a non-final result is pending
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request taken during merge");

endmodule

bind merge_two_sorted_lists_top mtsl_checker u_mtsl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
